// ===== src/pli_pkg.sv =====
// Shared constants, codes and types for the piecewise-linear interpolator.
`default_nettype none

package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int SEG_IDX_W = 6;
    localparam int STATUS_W = 3;
    localparam int OP_W = 2;

    // Slope division: |dy| << 16 divided by |dx|, one quotient bit a step.
    localparam int DVS_W = DATA_W;
    localparam int DVD_W = DATA_W + FRAC_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPEAT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] seg_start;
        logic signed [DATA_W-1:0] seg_end;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] icpt;
    } seg_entry_t;

    typedef struct packed {
        logic start;
        logic sub;
    } mac_req_t;

endpackage

`default_nettype wire

// ===== src/pli_if.sv =====
// Command and response channel interfaces of the piecewise-linear interpolator.
`default_nettype none

interface pli_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [pli_pkg::OP_W-1:0]              operation;
    logic signed [pli_pkg::DATA_W-1:0]     x_value;
    logic signed [pli_pkg::DATA_W-1:0]     y_value;

    modport source (output valid, output operation, output x_value, output y_value,
                    input ready);
    modport sink (input valid, input operation, input x_value, input y_value,
                  output ready);
endinterface

interface pli_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pli_pkg::DATA_W-1:0]     y_result;
    logic [pli_pkg::STATUS_W-1:0]          status;
    logic [pli_pkg::SEG_IDX_W-1:0]         segment_index;

    modport source (output valid, output y_result, output status, output segment_index,
                    input ready);
    modport sink (input valid, input y_result, input status, input segment_index,
                  output ready);
endinterface

`default_nettype wire

// ===== src/pli_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module pli_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pli_pkg::DVD_W-1:0]   dividend,
    input  wire logic [pli_pkg::DVS_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [pli_pkg::DVD_W-1:0]        quotient
);
    import pli_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       rem_shift;
    logic [DVS_W+1:0]     diff;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W+1])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/pli_mac.sv =====
// Two-stage unit computing sat(c + floor(a*b / 2^16)) or sat(c - floor(a*b / 2^16)).
`default_nettype none

module pli_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pli_pkg::mac_req_t                 req,
    input  wire logic signed [pli_pkg::DATA_W-1:0] a,
    input  wire logic signed [pli_pkg::DATA_W-1:0] b,
    input  wire logic signed [pli_pkg::DATA_W-1:0] c,
    output logic                                   done,
    output logic signed [pli_pkg::DATA_W-1:0]      result
);
    import pli_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = TERM_W + 2;

    logic                       prod_vld_reg;
    logic                       done_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DATA_W-1:0]   c_reg;
    logic                       sub_reg;
    logic signed [DATA_W-1:0]   result_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [TERM_W-1:0]   term;
    logic signed [SUM_W-1:0]    term_ext;
    logic signed [SUM_W-1:0]    c_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DATA_W-1:0]   sat_next;

    assign prod_next = a * b;

    // Dropping the low fraction bits of a two's-complement product rounds towards minus infinity.
    assign term     = prod_reg[PROD_W-1:FRAC_W];
    assign term_ext = {{2{term[TERM_W-1]}}, term};
    assign c_ext    = {{(SUM_W-DATA_W){c_reg[DATA_W-1]}}, c_reg};
    assign sum      = sub_reg ? (c_ext - term_ext) : (c_ext + term_ext);

    always_comb
    begin
        if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1)
        begin
            sat_next = sum[DATA_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= req.start;
            done_reg     <= prod_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
            c_reg    <= c;
            sub_reg  <= req.sub;
        end
        if (prod_vld_reg)
        begin
            result_reg <= sat_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/piecewise_linear_interpolator.sv =====
// Piecewise-linear interpolator in signed Q16.16: table build, clear and query.
//
// Usage: items arrive on the cmd channel (operation, x_value, y_value) and one
// response per item leaves on the rsp channel (y_result, status, segment_index).
// Both channels use a valid/ready handshake; an item moves when both are high.
// The block works on one item at a time and raises cmd.ready only when idle.
// Clear, an ignored code, a first or rejected load and a query on too few points
// go straight from acceptance to the result state and then to the output register.
// A load that closes a segment runs the 48-step bit-serial slope divider followed
// by the shared multiply-add unit that forms the intercept. A query reads the
// segment memory once per cycle in table order; a hit goes on to the multiply-add
// unit, and a miss is answered once every stored segment has been compared.
// The response sits in an output register, so a new item can be accepted while
// the receiver stalls; the following response then waits until that register
// has been taken. Reset empties the table and drops any pending response; the
// segment memory itself needs no clearing because only entries written since the
// last clear are ever read.
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pli_cmd_if.sink   cmd,
    pli_rsp_if.source rsp
);
    import pli_pkg::*;

    localparam int SEG_DEPTH = MAX_POINTS - 1;
    localparam int SEG_W = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SLOPE = 6'b000100,
        S_MAC   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [DATA_W-1:0]   last_x_reg, last_x_next;
    logic signed [DATA_W-1:0]   last_y_reg, last_y_next;
    logic signed [DATA_W-1:0]   x_reg, x_next;
    logic signed [DATA_W-1:0]   y_reg, y_next;
    logic                       is_load_reg, is_load_next;
    logic                       neg_reg, neg_next;
    logic signed [DATA_W-1:0]   slope_reg, slope_next;
    logic signed [DATA_W-1:0]   res_y_reg, res_y_next;
    logic [STATUS_W-1:0]        res_st_reg, res_st_next;
    logic [SEG_W-1:0]           res_seg_reg, res_seg_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [SEG_W-1:0]           rd_idx_reg, rd_idx_next;
    seg_entry_t                 rd_data_reg;
    logic                       out_vld_reg, out_vld_next;
    logic signed [DATA_W-1:0]   out_y_reg;
    logic [STATUS_W-1:0]        out_st_reg;
    logic [SEG_IDX_W-1:0]       out_seg_reg;

    seg_entry_t                 seg_mem [SEG_DEPTH];

    logic                       accept;
    logic                       out_load;
    logic                       rd_en;
    logic                       wr_en;
    logic [CNT_W-1:0]           seg_count;
    logic [SEG_W-1:0]           wr_addr;
    seg_entry_t                 wr_data;
    logic                       hit;
    logic [DATA_W:0]            dx;
    logic [DATA_W:0]            dy;
    logic [DATA_W:0]            dx_mag;
    logic [DATA_W:0]            dy_mag;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [DVD_W-1:0]           div_quo;
    logic signed [DATA_W-1:0]   slope_sat;
    mac_req_t                   mac_req;
    logic signed [DATA_W-1:0]   mac_a;
    logic signed [DATA_W-1:0]   mac_b;
    logic signed [DATA_W-1:0]   mac_c;
    logic                       mac_done;
    logic signed [DATA_W-1:0]   mac_result;
    logic [SEG_W+SEG_IDX_W-1:0] res_seg_wide;

    assign accept    = cmd.valid && (state_reg == S_IDLE);
    assign seg_count = count_reg - 1'b1;
    assign wr_addr   = seg_count[SEG_W-1:0];
    assign out_load  = (state_reg == S_DONE) && (!out_vld_reg || rsp.ready);

    assign dx     = {cmd.x_value[DATA_W-1], cmd.x_value} - {last_x_reg[DATA_W-1], last_x_reg};
    assign dy     = {cmd.y_value[DATA_W-1], cmd.y_value} - {last_y_reg[DATA_W-1], last_y_reg};
    assign dx_mag = dx[DATA_W] ? (~dx + 1'b1) : dx;
    assign dy_mag = dy[DATA_W] ? (~dy + 1'b1) : dy;

    assign hit = rd_vld_reg && (x_reg >= rd_data_reg.seg_start) && (x_reg <= rd_data_reg.seg_end);

    // Truncated quotient magnitude, signed and saturated to 32 bits.
    always_comb
    begin
        if (neg_reg)
        begin
            if (div_quo[DVD_W-1:DATA_W] != '0 ||
                (div_quo[DATA_W-1] && div_quo[DATA_W-2:0] != '0))
            begin
                slope_sat = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                slope_sat = ~div_quo[DATA_W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (div_quo[DVD_W-1:DATA_W-1] != '0)
            begin
                slope_sat = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                slope_sat = div_quo[DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        is_load_next = is_load_reg;
        neg_next     = neg_reg;
        slope_next   = slope_reg;
        res_y_next   = res_y_reg;
        res_st_next  = res_st_reg;
        res_seg_next = res_seg_reg;
        issue_next   = issue_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = {last_x_reg, x_reg, slope_reg, mac_result};
        div_start    = 1'b0;
        mac_req      = '0;
        mac_a        = rd_data_reg.slope;
        mac_b        = x_reg;
        mac_c        = rd_data_reg.icpt;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next       = cmd.x_value;
                    y_next       = cmd.y_value;
                    res_y_next   = '0;
                    res_st_next  = ST_OK;
                    res_seg_next = '0;
                    state_next   = S_DONE;
                    case (cmd.operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (count_reg == '0)
                            begin
                                last_x_next = cmd.x_value;
                                last_y_next = cmd.y_value;
                                count_next  = CNT_W'(1);
                            end
                            else if (count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                res_st_next = ST_FULL;
                            end
                            else if (cmd.x_value == last_x_reg)
                            begin
                                res_st_next = ST_REPEAT;
                            end
                            else
                            begin
                                is_load_next = 1'b1;
                                neg_next     = dx[DATA_W] ^ dy[DATA_W];
                                div_start    = 1'b1;
                                state_next   = S_DIV;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                res_st_next = ST_FEW;
                            end
                            else
                            begin
                                is_load_next = 1'b0;
                                issue_next   = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SLOPE;
                end
            end
            S_SLOPE:
            begin
                slope_next    = slope_sat;
                mac_req.start = 1'b1;
                mac_req.sub   = 1'b1;
                mac_a         = slope_sat;
                mac_b         = last_x_reg;
                mac_c         = last_y_reg;
                state_next    = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    if (is_load_reg)
                    begin
                        wr_en        = 1'b1;
                        last_x_next  = x_reg;
                        last_y_next  = y_reg;
                        count_next   = count_reg + 1'b1;
                        res_seg_next = wr_addr;
                    end
                    else
                    begin
                        res_y_next = mac_result;
                    end
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                // Reads run one entry ahead of the compare on the registered read data.
                if (hit)
                begin
                    mac_req.start = 1'b1;
                    mac_req.sub   = 1'b0;
                    res_seg_next  = rd_idx_reg;
                    state_next    = S_MAC;
                end
                else
                begin
                    if (issue_reg < seg_count)
                    begin
                        rd_en       = 1'b1;
                        rd_vld_next = 1'b1;
                        rd_idx_next = issue_reg[SEG_W-1:0];
                        issue_next  = issue_reg + 1'b1;
                    end
                    else if (rd_vld_reg)
                    begin
                        res_st_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            is_load_reg <= 1'b0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            is_load_reg <= is_load_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign res_seg_wide = {{SEG_IDX_W{1'b0}}, res_seg_reg};

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        neg_reg     <= neg_next;
        slope_reg   <= slope_next;
        res_y_reg   <= res_y_next;
        res_st_reg  <= res_st_next;
        res_seg_reg <= res_seg_next;
        rd_idx_reg  <= rd_idx_next;
        if (out_load)
        begin
            out_y_reg   <= res_y_reg;
            out_st_reg  <= res_st_reg;
            out_seg_reg <= res_seg_wide[SEG_IDX_W-1:0];
        end
    end

    // Segment memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= seg_mem[issue_reg[SEG_W-1:0]];
        end
    end

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dy_mag[DATA_W-1:0], {FRAC_W{1'b0}}}),
        .divisor  (dx_mag[DATA_W-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    pli_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mac_req),
        .a      (mac_a),
        .b      (mac_b),
        .c      (mac_c),
        .done   (mac_done),
        .result (mac_result)
    );

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_vld_reg;
    assign rsp.y_result      = out_y_reg;
    assign rsp.status        = out_st_reg;
    assign rsp.segment_index = out_seg_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above table size");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != '0 && count_reg < CNT_W'(MAX_POINTS)))
        else $error("segment write outside the table");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the result state");

    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV)
        else $error("divider running outside the division state");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise-linear interpolator: table builds, queries, stalls.

module tb;

    import pli_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int SEG_DEPTH = MAX_POINTS_DEF - 1;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483647 - 64'sd1;
    localparam int ITEM_TARGET = 1300;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 150;
    localparam longint LIMIT_CYCLES = 1000000;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } cmd_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] y_result;
        logic [STATUS_W-1:0]      status;
        logic [SEG_IDX_W-1:0]     segment_index;
    } rsp_item_t;

    logic clk;
    logic rst_n;

    pli_cmd_if cmd_bus ();
    pli_rsp_if rsp_bus ();

    piecewise_linear_interpolator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the segment table.
    int     tbl_points = 0;
    longint tbl_last_x = 0;
    longint tbl_last_y = 0;
    longint tbl_start [SEG_DEPTH];
    longint tbl_end [SEG_DEPTH];
    longint tbl_slope [SEG_DEPTH];
    longint tbl_icpt [SEG_DEPTH];

    cmd_item_t pending_cmds [$];
    rsp_item_t expected_rsps [$];
    int        live_items;

    cmd_item_t cur_cmd;
    int        send_gap;
    int        items_sent;

    int        recv_stall;
    int        results_seen;
    int        fail_count = 0;
    logic      hold_off;
    logic      hold_done;
    int        hold_cnt;
    longint    cycle_cnt = 0;

    function automatic longint clamp_q32(longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Updates the shadow table for one command and returns the response it must produce.
    function automatic rsp_item_t interpolate_cmd(cmd_item_t it);
        rsp_item_t r;
        longint    x;
        longint    y;
        longint    dx;
        longint    dy;
        longint    m;
        longint    b;
        longint    yres;
        int        k;
        int        n;
        x = it.x;
        y = it.y;
        yres = 0;
        r.status = ST_OK;
        r.segment_index = '0;
        case (it.op)
            OP_CLEAR: tbl_points = 0;
            OP_LOAD:
            begin
                if (tbl_points == 0)
                begin
                    tbl_last_x = x;
                    tbl_last_y = y;
                    tbl_points = 1;
                end
                else if (tbl_points >= MAX_POINTS_DEF)
                    r.status = ST_FULL;
                else if (x == tbl_last_x)
                    r.status = ST_REPEAT;
                else
                begin
                    k = tbl_points - 1;
                    dx = x - tbl_last_x;
                    dy = y - tbl_last_y;
                    m = clamp_q32((dy * 65536) / dx);
                    // Arithmetic shift of the exact product gives the floor.
                    b = clamp_q32(tbl_last_y - ((m * tbl_last_x) >>> FRAC_W));
                    tbl_start[k] = tbl_last_x;
                    tbl_end[k] = x;
                    tbl_slope[k] = m;
                    tbl_icpt[k] = b;
                    tbl_last_x = x;
                    tbl_last_y = y;
                    tbl_points++;
                    r.segment_index = k[SEG_IDX_W-1:0];
                end
            end
            OP_QUERY:
            begin
                if (tbl_points < 2)
                    r.status = ST_FEW;
                else
                begin
                    n = (tbl_points - 1 > SEG_DEPTH) ? SEG_DEPTH : tbl_points - 1;
                    r.status = ST_RANGE;
                    for (int i = 0; i < n; i++)
                    begin
                        if (x >= tbl_start[i] && x <= tbl_end[i])
                        begin
                            yres = clamp_q32(((tbl_slope[i] * x) >>> FRAC_W) + tbl_icpt[i]);
                            r.segment_index = i[SEG_IDX_W-1:0];
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.y_result = yres[DATA_W-1:0];
        return r;
    endfunction

    function automatic longint rand_q32();
        return longint'($signed($urandom));
    endfunction

    task automatic push_cmd(logic [OP_W-1:0] op, longint x, longint y);
        cmd_item_t it;
        it.op = op;
        it.x = x[DATA_W-1:0];
        it.y = y[DATA_W-1:0];
        pending_cmds.push_back(it);
        if (op != OP_IGNORED)
            live_items++;
    endtask

    // A clear, a run of loads along a mostly rising x, then queries over the built table.
    task automatic add_curve();
        int     n;
        int     s;
        int     step;
        int     pick;
        longint span;
        longint hi;
        longint x;
        longint y;
        longint lo_x;
        longint hi_x;
        longint qx;
        longint xs [$];
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 8);
        s = $urandom_range(0, (n > 10) ? 23 : 27);
        step = 1 << s;
        span = longint'(n) * step;
        hi = Q_MAX - span;
        x = rand_q32();
        if (x > hi)
            x = x - span;
        lo_x = x;
        hi_x = x;
        push_cmd(OP_CLEAR, rand_q32(), rand_q32());
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                y = rand_q32();
            else
                y = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            if (i > 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    ; // same x again: the load must be refused
                else if (pick == 1 && x - step >= Q_MIN)
                    x = x - $urandom_range(1, step);
                else
                    x = x + $urandom_range(1, step);
            end
            xs.push_back(x);
            if (x < lo_x)
                lo_x = x;
            if (x > hi_x)
                hi_x = x;
            push_cmd(OP_LOAD, x, y);
        end
        repeat ($urandom_range(1, 10))
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                qx = lo_x + longint'($urandom) % (hi_x - lo_x + 1);
            else if (pick < 7)
                qx = xs[$urandom_range(0, xs.size() - 1)];
            else if (pick == 7)
                qx = (lo_x > Q_MIN) ? lo_x - 1 : lo_x;
            else if (pick == 8)
                qx = (hi_x < Q_MAX) ? hi_x + 1 : hi_x;
            else
                qx = rand_q32();
            push_cmd(OP_QUERY, qx, rand_q32());
        end
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 4))
            push_cmd(2'($urandom_range(0, 3)), rand_q32(), rand_q32());
    endtask

    task automatic build_directed();
        push_cmd(OP_QUERY, 0, 0);                 // nothing loaded yet
        push_cmd(OP_IGNORED, Q_MAX, Q_MIN);
        push_cmd(OP_CLEAR, 0, 0);
        push_cmd(OP_LOAD, 0, 0);
        push_cmd(OP_QUERY, 0, 0);                 // a single point is too few
        push_cmd(OP_LOAD, 0, 'h5_0000);           // same x as the last point
        push_cmd(OP_LOAD, 'h1_0000, 'h2_0000);
        push_cmd(OP_LOAD, 'h3_0000, -'h1_0000);
        push_cmd(OP_QUERY, 0, 0);
        push_cmd(OP_QUERY, 'h1_0000, 0);          // shared end point goes to the first segment
        push_cmd(OP_QUERY, 'h3_0000, 0);
        push_cmd(OP_QUERY, 'h2_8000, 0);
        push_cmd(OP_QUERY, -1, 0);
        push_cmd(OP_QUERY, 'h3_0001, 0);
        push_cmd(OP_CLEAR, Q_MIN, Q_MAX);
        push_cmd(OP_LOAD, 'h5_0000, 0);
        push_cmd(OP_LOAD, 'h4_0000, 'h1_0000);    // end below start holds no x
        push_cmd(OP_QUERY, 'h4_8000, 0);
        push_cmd(OP_CLEAR, 0, 0);
        push_cmd(OP_LOAD, Q_MIN, Q_MIN);
        push_cmd(OP_LOAD, Q_MAX, Q_MAX);
        push_cmd(OP_QUERY, Q_MIN, 0);
        push_cmd(OP_QUERY, Q_MAX, 0);
        push_cmd(OP_CLEAR, 0, 0);
        push_cmd(OP_LOAD, 0, Q_MIN);
        push_cmd(OP_LOAD, 1, Q_MAX);              // slope saturates high
        push_cmd(OP_QUERY, 1, 0);
        push_cmd(OP_LOAD, 2, Q_MIN);              // slope saturates low
        push_cmd(OP_QUERY, 2, 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        live_items = 0;
        build_directed();
        while (live_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                add_noise();
            else
                add_curve();
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("piecewise_linear_interpolator verification clean");
        else
            $display("piecewise_linear_interpolator verification failed");
        $finish;
    end

    // Sender: one item at a time from the pending queue, with a random gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.operation <= OP_CLEAR;
            cmd_bus.x_value <= '0;
            cmd_bus.y_value <= '0;
            send_gap <= 0;
            items_sent <= 0;
        end
        else if (cmd_bus.valid && cmd_bus.ready)
        begin : accept
            int g;
            expected_rsps.push_back(interpolate_cmd(cur_cmd));
            items_sent <= items_sent + 1;
            g = ((items_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (g == 0 && pending_cmds.size() != 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                cmd_bus.operation <= cur_cmd.op;
                cmd_bus.x_value <= cur_cmd.x;
                cmd_bus.y_value <= cur_cmd.y;
            end
            else
            begin
                cmd_bus.valid <= 1'b0;
                send_gap <= g;
            end
        end
        else if (!cmd_bus.valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_cmds.size() != 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                cmd_bus.valid <= 1'b1;
                cmd_bus.operation <= cur_cmd.op;
                cmd_bus.x_value <= cur_cmd.x;
                cmd_bus.y_value <= cur_cmd.y;
            end
        end
    end

    // Receiver: checks each response against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            recv_stall <= 0;
            results_seen <= 0;
        end
        else
        begin : receive
            int        s;
            rsp_item_t exp_rsp;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_bus.y_result !== exp_rsp.y_result)
                    begin
                        $error("y_result mismatch: expected %0d, got %0d",
                               exp_rsp.y_result, rsp_bus.y_result);
                        fail_count++;
                    end
                    if (rsp_bus.status !== exp_rsp.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               exp_rsp.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.segment_index !== exp_rsp.segment_index)
                    begin
                        $error("segment_index mismatch: expected %0d, got %0d",
                               exp_rsp.segment_index, rsp_bus.segment_index);
                        fail_count++;
                    end
                end
                s = ((results_seen / 120) % 3 == 2) ? 0 : $urandom_range(0, 5);
            end
            else
                s = (recv_stall > 0) ? recv_stall - 1 : 0;
            recv_stall <= s;
            rsp_bus.ready <= (s == 0) && !hold_off;
        end
    end

    // One long receiver hold-off so that the output register fills and the input stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_off)
        begin
            if (hold_cnt == 0)
            begin
                hold_off <= 1'b0;
                hold_done <= 1'b1;
            end
            else
                hold_cnt <= hold_cnt - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_off <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("piecewise_linear_interpolator verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/pli_pkg.sv
src/pli_if.sv
src/pli_div.sv
src/pli_mac.sv
src/piecewise_linear_interpolator.sv
verif/tb.sv
